### design/mi_pkg.sv
// shared widths, latency and control types for the 3x3 matrix inverse
package mi_pkg;

    localparam int ElemW   = 32;
    localparam int ProdW   = 2 * ElemW;
    localparam int CofW    = ProdW + 1;
    localparam int MagW    = ProdW;
    localparam int DetW    = 3 * ElemW + 1;
    localparam int DmagW   = DetW - 1;
    localparam int NumElem = 9;
    localparam int DataW   = NumElem * ElemW;

    // pipeline depth of each unit
    localparam int CofLat  = 2;
    localparam int DetLat  = 4;
    localparam int DivLat  = ElemW + 2;
    localparam int TotLat  = CofLat + DetLat + DivLat;

    localparam logic [ElemW-1:0] SatPos = {1'b0, {(ElemW-1){1'b1}}};
    localparam logic [ElemW-1:0] SatNeg = {1'b1, {(ElemW-1){1'b0}}};

    // per-element control riding along with the divide
    typedef struct packed {
        logic neg;
        logic sing;
    } lane_ctl_t;

endpackage

### design/mi_cofactor.sv
// two-stage cofactor unit: products of element pairs, then differences
module mi_cofactor
    import mi_pkg::*;
(
    input  logic                           aclk,
    input  logic                           en,
    input  logic [NumElem-1:0][ElemW-1:0]  elem,
    output logic [NumElem-1:0][CofW-1:0]   cof,
    output logic [2:0][ElemW-1:0]          col0
);

    logic signed [ProdW-1:0] p1_reg [NumElem];
    logic signed [ProdW-1:0] p2_reg [NumElem];
    logic [CofW-1:0]         cof_reg [NumElem];
    logic [ElemW-1:0]        c0a_reg [3];
    logic [ElemW-1:0]        c0b_reg [3];

    for (genvar j = 0; j < NumElem; j++) begin : g_el
        localparam int K  = j / 3;
        localparam int I  = j % 3;
        localparam int K1 = (K + 1) % 3;
        localparam int K2 = (K + 2) % 3;
        localparam int I1 = (I + 1) % 3;
        localparam int I2 = (I + 2) % 3;

        // element of row r, column c sits at c*3+r
        always_ff @(posedge aclk) begin
            if (en) begin
                p1_reg[j]  <= $signed(elem[I1*3+K1]) * $signed(elem[I2*3+K2]);
                p2_reg[j]  <= $signed(elem[I2*3+K1]) * $signed(elem[I1*3+K2]);
                cof_reg[j] <= {p1_reg[j][ProdW-1], p1_reg[j]}
                            - {p2_reg[j][ProdW-1], p2_reg[j]};
            end
        end
        assign cof[j] = cof_reg[j];
    end

    // first column travels with the cofactors
    for (genvar k = 0; k < 3; k++) begin : g_col
        always_ff @(posedge aclk) begin
            if (en) begin
                c0a_reg[k] <= elem[k];
                c0b_reg[k] <= c0a_reg[k];
            end
        end
        assign col0[k] = c0b_reg[k];
    end

endmodule

### design/mi_det.sv
// four-stage determinant unit with sign and magnitude split of cofactors
module mi_det
    import mi_pkg::*;
(
    input  logic                          aclk,
    input  logic                          en,
    input  logic [NumElem-1:0][CofW-1:0]  cof,
    input  logic [2:0][ElemW-1:0]         col0,
    output logic [DmagW-1:0]              dmag,
    output logic [NumElem-1:0][MagW-1:0]  cmag,
    output lane_ctl_t [NumElem-1:0]       ctl
);

    logic signed [CofW-1:0]  ph_reg [3];
    logic signed [CofW-1:0]  pl_reg [3];
    logic [DetW-1:0]         term_reg [3];
    logic [DetW-1:0]         det_reg;
    logic [CofW-1:0]         c3_reg [NumElem];
    logic [CofW-1:0]         c4_reg [NumElem];
    logic [CofW-1:0]         c5_reg [NumElem];
    logic [DmagW-1:0]        dmag_reg;
    logic [MagW-1:0]         cmag_reg [NumElem];
    lane_ctl_t               ctl_reg [NumElem];
    logic                    dneg;
    logic [DetW-1:0]         dabs;

    // partial products of column 0 with the upper and lower cofactor halves
    for (genvar k = 0; k < 3; k++) begin : g_term
        always_ff @(posedge aclk) begin
            if (en) begin
                ph_reg[k]   <= $signed(col0[k]) * $signed(cof[k*3][CofW-1:ElemW]);
                pl_reg[k]   <= $signed(col0[k]) * $signed({1'b0, cof[k*3][ElemW-1:0]});
                term_reg[k] <= {ph_reg[k], {ElemW{1'b0}}}
                             + {{(DetW-CofW){pl_reg[k][CofW-1]}}, pl_reg[k]};
            end
        end
    end

    // determinant sum
    always_ff @(posedge aclk) begin
        if (en) begin
            det_reg <= term_reg[0] + term_reg[1] + term_reg[2];
        end
    end

    assign dneg = det_reg[DetW-1];
    assign dabs = dneg ? (~det_reg + DetW'(1)) : det_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            dmag_reg <= dabs[DmagW-1:0];
        end
    end
    assign dmag = dmag_reg;

    // cofactor delay and magnitude split
    for (genvar j = 0; j < NumElem; j++) begin : g_el
        logic [CofW-1:0] cabs;
        assign cabs = c5_reg[j][CofW-1] ? (~c5_reg[j] + CofW'(1)) : c5_reg[j];
        always_ff @(posedge aclk) begin
            if (en) begin
                c3_reg[j]       <= cof[j];
                c4_reg[j]       <= c3_reg[j];
                c5_reg[j]       <= c4_reg[j];
                cmag_reg[j]     <= cabs[MagW-1:0];
                ctl_reg[j].neg  <= c5_reg[j][CofW-1] ^ dneg;
                ctl_reg[j].sing <= (det_reg == '0);
            end
        end
        assign cmag[j] = cmag_reg[j];
        assign ctl[j]  = ctl_reg[j];
    end

endmodule

### design/mi_div_lane.sv
// one element: restoring divide, one quotient bit per stage, then saturation
module mi_div_lane
    import mi_pkg::*;
(
    input  logic              aclk,
    input  logic              en,
    input  logic [MagW-1:0]   cmag,
    input  logic [DmagW-1:0]  dmag,
    input  lane_ctl_t         ctl,
    output logic [ElemW-1:0]  res,
    output logic              sing
);

    logic [DmagW-1:0] r_reg   [ElemW+1];
    logic [DmagW-1:0] d_reg   [ElemW+1];
    logic [ElemW-1:0] q_reg   [ElemW+1];
    logic             ovf_reg [ElemW+1];
    lane_ctl_t        ctl_reg [ElemW+1];
    logic [ElemW-1:0] res_reg;
    logic             sing_reg;
    logic [ElemW-1:0] res_next;

    // entry: quotient of 2^32 or more when cofactor magnitude reaches divisor
    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg[0]   <= {{(DmagW-MagW){1'b0}}, cmag};
            d_reg[0]   <= dmag;
            q_reg[0]   <= '0;
            ovf_reg[0] <= ({{(DmagW-MagW){1'b0}}, cmag} >= dmag);
            ctl_reg[0] <= ctl;
        end
    end

    // quotient bit stages
    for (genvar i = 0; i < ElemW; i++) begin : g_stage
        logic [DmagW:0] t;
        logic [DmagW:0] diff;
        logic           ge;
        assign t    = {r_reg[i], 1'b0};
        assign diff = t - {1'b0, d_reg[i]};
        assign ge   = (t >= {1'b0, d_reg[i]});
        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[i+1]   <= ge ? diff[DmagW-1:0] : t[DmagW-1:0];
                d_reg[i+1]   <= d_reg[i];
                q_reg[i+1]   <= {q_reg[i][ElemW-2:0], ge};
                ovf_reg[i+1] <= ovf_reg[i];
                ctl_reg[i+1] <= ctl_reg[i];
            end
        end
    end

    // singular zeroing, sign and saturation
    always_comb begin
        if (ctl_reg[ElemW].sing) begin
            res_next = '0;
        end else if (ctl_reg[ElemW].neg) begin
            if (ovf_reg[ElemW] || q_reg[ElemW][ElemW-1]) begin
                res_next = SatNeg;
            end else begin
                res_next = ~q_reg[ElemW] + ElemW'(1);
            end
        end else begin
            if (ovf_reg[ElemW] || q_reg[ElemW][ElemW-1]) begin
                res_next = SatPos;
            end else begin
                res_next = q_reg[ElemW];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg  <= res_next;
            sing_reg <= ctl_reg[ElemW].sing;
        end
    end

    assign res  = res_reg;
    assign sing = sing_reg;

endmodule

### design/matrix3x3_inverse.sv
// top level of the 3x3 Q16.16 matrix inverse pipeline
//
// usage:
// - s_ channel takes one matrix per request: nine signed Q16.16 elements,
//   column by column, element c*3+r in s_tdata bits [32*(c*3+r) +: 32]
// - m_ channel gives the nine inverse elements in the same order, each
//   truncated toward zero and saturated, and m_tuser = singular
// - a singular matrix (determinant zero) returns all zeros with m_tuser high
// - the pipeline runs the cofactors, the determinant, the divide set-up,
//   32 restoring divide stages (one quotient bit each) and saturation
// - throughput is one matrix per cycle unless the output stalls; the divide
//   stages are unrolled so each stage can hold a different matrix
// - when m_tready is low with a result waiting, the whole pipeline holds and
//   s_tready drops in the same cycle; empty stages are not squeezed out
// - reset clears all valid bits; data registers are not reset
module matrix3x3_inverse
    import mi_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    // c0_r0, c0_r1, c0_r2, c1_r0, c1_r1, c1_r2, c2_r0, c2_r1, c2_r2
    input  logic [DataW-1:0]  s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    // inv_c0_r0, inv_c0_r1, ... inv_c2_r2
    output logic [DataW-1:0]  m_tdata,
    // singular
    output logic              m_tuser
);

    logic [TotLat-1:0]                 v_reg;
    logic [TotLat-1:0]                 v_next;
    logic                              en;
    logic [NumElem-1:0][ElemW-1:0]     elem;
    logic [NumElem-1:0][CofW-1:0]      cof;
    logic [2:0][ElemW-1:0]             col0;
    logic [DmagW-1:0]                  dmag;
    logic [NumElem-1:0][MagW-1:0]      cmag;
    lane_ctl_t [NumElem-1:0]           ctl;
    logic [NumElem-1:0][ElemW-1:0]     res;
    logic [NumElem-1:0]                sing;

    // global advance: hold only when a result waits on the output
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign m_tvalid = v_reg[TotLat-1];

    // valid bits travel with the data
    assign v_next = {v_reg[TotLat-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= v_next;
        end
    end

    assign elem = s_tdata;

    mi_cofactor u_cof (
        .aclk (aclk),
        .en   (en),
        .elem (elem),
        .cof  (cof),
        .col0 (col0)
    );

    mi_det u_det (
        .aclk (aclk),
        .en   (en),
        .cof  (cof),
        .col0 (col0),
        .dmag (dmag),
        .cmag (cmag),
        .ctl  (ctl)
    );

    for (genvar j = 0; j < NumElem; j++) begin : g_lane
        mi_div_lane u_lane (
            .aclk (aclk),
            .en   (en),
            .cmag (cmag[j]),
            .dmag (dmag),
            .ctl  (ctl[j]),
            .res  (res[j]),
            .sing (sing[j])
        );
    end

    assign m_tdata = res;
    assign m_tuser = sing[0];

    // singular results carry all-zero elements
    a_sing_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("singular result with nonzero elements");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a waiting result blocks new requests
    a_stall_block: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("request taken while output stalled");

endmodule

### test/testbench.sv
// self-checking testbench for the 3x3 q16.16 matrix inverse
`timescale 1ns / 100ps

module testbench;
    import mi_pkg::*;

    typedef logic signed [31:0] elem_t;
    typedef elem_t mat9_t [9];

    typedef struct {
        logic [DataW-1:0] data;
        logic             sing;
    } inv_result_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [DataW-1:0] s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [DataW-1:0] m_tdata;
    logic             m_tuser;

    inv_result_t inverse_queue[$];
    int          mismatches = 0;
    int          results_seen = 0;
    int          singular_seen = 0;
    int          saturated_seen = 0;
    int          requests_sent = 0;
    longint      cycles = 0;
    bit          stall_enable = 1'b1;

    localparam longint CycleLimit = 2000000;

    matrix3x3_inverse uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    always #5 aclk = ~aclk;

    // cycle limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // exact inverse: cofactors, determinant, truncating divide, saturation
    function automatic inv_result_t predict_inverse(mat9_t m);
        logic signed [65:0]  cof [3][3];
        logic signed [127:0] det;
        logic signed [127:0] num;
        logic signed [127:0] quo;
        logic signed [31:0]  a [3][3];
        inv_result_t         res;
        int                  k1, k2, i1, i2;
        for (int c = 0; c < 3; c++)
            for (int r = 0; r < 3; r++)
                a[r][c] = m[c * 3 + r];
        for (int k = 0; k < 3; k++)
            for (int i = 0; i < 3; i++) begin
                k1 = (k + 1) % 3; k2 = (k + 2) % 3;
                i1 = (i + 1) % 3; i2 = (i + 2) % 3;
                cof[k][i] = 66'(a[k1][i1]) * 66'(a[k2][i2])
                          - 66'(a[k1][i2]) * 66'(a[k2][i1]);
            end
        det = 0;
        for (int k = 0; k < 3; k++)
            det = det + 128'(a[k][0]) * 128'(cof[k][0]);
        res.data = '0;
        res.sing = (det == 0);
        if (!res.sing) begin
            for (int e = 0; e < 9; e++) begin
                // sv signed divide truncates toward zero
                num = 128'(cof[e / 3][e % 3]) <<< 32;
                quo = num / det;
                if (quo > 128'sd2147483647)
                    res.data[32 * e +: 32] = SatPos;
                else if (quo < -128'sd2147483648)
                    res.data[32 * e +: 32] = SatNeg;
                else
                    res.data[32 * e +: 32] = quo[31:0];
            end
        end
        return res;
    endfunction

    // send one matrix request, after a random gap when gaps is set
    task automatic send_matrix(mat9_t m, bit gaps = 1'b1);
        int wait_cycles;
        wait_cycles = gaps ? $urandom_range(0, 14) : 0;
        if ($urandom_range(0, 3) == 0) wait_cycles = 0;
        if (wait_cycles > 0) begin
            s_tvalid <= 1'b0;
            repeat (wait_cycles) @(negedge aclk);
        end
        for (int e = 0; e < 9; e++) s_tdata[32 * e +: 32] <= m[e];
        s_tvalid <= 1'b1;
        inverse_queue.push_back(predict_inverse(m));
        do @(posedge aclk); while (!s_tready);
        requests_sent++;
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (inverse_queue.size() != 0) @(negedge aclk);
    endtask

    // result checker
    always @(posedge aclk) begin
        inv_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (inverse_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", m_tdata);
            end else begin
                exp_r = inverse_queue.pop_front();
                if (exp_r.sing) singular_seen++;
                for (int e = 0; e < 9; e++)
                    if (exp_r.data[32 * e +: 32] == SatPos
                        || exp_r.data[32 * e +: 32] == SatNeg)
                        saturated_seen++;
                if (m_tdata !== exp_r.data || m_tuser !== exp_r.sing) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %h sing %b, got %h sing %b",
                                 exp_r.data, exp_r.sing, m_tdata, m_tuser);
                end
            end
        end
    end

    // receiver stalls: random runs of ready low
    initial begin
        int stall;
        forever begin
            @(negedge aclk);
            stall = stall_enable ? $urandom_range(0, 14) : 0;
            if ($urandom_range(0, 2) == 0) stall = 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    function automatic elem_t rand_elem(int shape);
        case (shape)
            0: return elem_t'($urandom);
            1: return elem_t'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000);
            2: return elem_t'($signed($urandom_range(0, 32'h1FF)) - 32'sh100);
            default: return elem_t'($signed($urandom_range(0, 32'h7FFFFF))
                                    - 32'sh400000);
        endcase
    endfunction

    task automatic test_directed();
        mat9_t m;
        // identity, zero, scaled identity
        m = '{32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000};
        send_matrix(m);
        m = '{default: 0};
        send_matrix(m);
        m = '{32'h20000, 0, 0, 0, -32'sh40000, 0, 0, 0, 32'h8000};
        send_matrix(m);
        // singular: equal columns
        m = '{32'h10000, 32'h20000, 32'h30000, 32'h10000, 32'h20000, 32'h30000,
              5, 6, 7};
        send_matrix(m);
        // tiny determinant saturates both ways
        m = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
        send_matrix(m);
        m = '{-1, 0, 0, 0, 1, 0, 0, 0, 1};
        send_matrix(m);
        // extreme elements
        m = '{default: 32'h80000000};
        send_matrix(m);
        m = '{32'h80000000, 0, 0, 0, 32'h7FFFFFFF, 0, 0, 0, 32'h80000000};
        send_matrix(m);
        m = '{32'h7FFFFFFF, 1, 0, 32'h80000000, 32'h7FFFFFFF, 2, 3, -1,
              32'h7FFFFFFF};
        send_matrix(m);
        m = '{-1, -1, 0, 1, -1, 0, 0, 0, -1};
        send_matrix(m);
        // truncation toward zero with a negative determinant
        m = '{32'h30000, 0, 0, 0, -32'sh10000, 0, 0, 0, 32'h10000};
        send_matrix(m);
        m = '{32'h10000, 32'h20000, 0, 32'h30000, 32'h40000, 0, 7, 9,
              32'h70000};
        send_matrix(m);
        // permutation
        m = '{0, 32'h10000, 0, 32'h10000, 0, 0, 0, 0, 32'h10000};
        send_matrix(m);
    endtask

    task automatic test_random(int count);
        mat9_t m;
        int    shape;
        for (int n = 0; n < count; n++) begin
            shape = $urandom_range(0, 3);
            for (int e = 0; e < 9; e++) m[e] = rand_elem(shape);
            // some rank-deficient matrices: copy one column to another
            if ($urandom_range(0, 9) == 0)
                for (int r = 0; r < 3; r++) m[6 + r] = m[r];
            send_matrix(m);
        end
    endtask

    task automatic test_back_to_back(int count);
        mat9_t m;
        stall_enable = 1'b0;
        for (int n = 0; n < count; n++) begin
            for (int e = 0; e < 9; e++) m[e] = rand_elem(n % 4);
            send_matrix(m, 1'b0);
        end
        stall_enable = 1'b1;
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        // pause until the pipeline has emptied
        drain_results();
        test_random(1200);
        test_back_to_back(240);
        drain_results();
        repeat (TotLat + 10) @(negedge aclk);
        $display("sent %0d matrices, checked %0d inverses", requests_sent, results_seen);
        $display("%0d singular, %0d saturated elements", singular_seen, saturated_seen);
        if (mismatches == 0 && inverse_queue.size() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
